@@ src/vna_pkg.sv @@
// shared constants and types for the vertex normal accumulator
package vna_pkg;

  localparam int VERTICES_DEF = 1024;
  localparam int POS_W        = 16;
  localparam int ACC_W        = 48;
  localparam int CR_W         = 35;
  localparam int SUM_W        = 62;
  localparam int CNT_W        = 11;
  localparam int THR_W        = 32;
  localparam int CMP_W        = 18;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TRI  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] CFG_VCOUNT = 2'd0;
  localparam logic [1:0] CFG_MINLEN = 2'd1;

  localparam logic [THR_W-1:0] THR_RESET = 32'd281474977;
  localparam logic signed [15:0] NORM_ONE = 16'sd16384;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [CR_W-1:0]  cr_t;

endpackage

@@ src/vertex_normal_accumulator.sv @@
// vertex normal accumulator top level: sequencer, memories and datapath
//
// channel | direction | signals
// in      | into      | in_valid, in_stall, mode, vertex, pos_*, corner_*
// out     | out of    | out_valid, out_stall, norm_*, degenerate, status
// cfg     | into      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// load: written from the idle state. triangle: busy for 4 position reads, the
// cross product on the shared multiplier and 3 accumulator read-modify-writes
// on one port. read: at most a shift loop, 32 root steps and 3 x 16 divide
// steps. after reset a clearing pass over all VERTICES entries zeroes the
// accumulators while in_stall is high. out_stall holds the finished beat.
module vertex_normal_accumulator
  import vna_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [9:0]         vertex,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [11:0] corner_a,
  input  logic signed [11:0] corner_b,
  input  logic signed [11:0] corner_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic               degenerate,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = $clog2(VERTICES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_TRI  = 4'd2;
  localparam logic [3:0] S_EDGE = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_RDN  = 4'd6;
  localparam logic [3:0] S_DEG  = 4'd7;
  localparam logic [3:0] S_SHF  = 4'd8;
  localparam logic [3:0] S_SQ   = 4'd9;
  localparam logic [3:0] S_SQRT = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]       state;
  logic [AW-1:0]    clr_addr;
  logic [CNT_W-1:0] vertex_count;
  logic [THR_W-1:0] min_length_squared;
  logic [2:0]       k;
  logic [4:0]       cnt;
  logic [1:0]       i;
  logic             chk;

  logic [AW-1:0]    idx [3];
  pos_t             pa [3];
  pos_t             pb [3];
  pos_t             pc [3];
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  cr_t              cr [3];
  logic [ACC_W-1:0] m [3];
  logic [2:0]       sgn;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sx;
  logic [62:0]      sr;
  logic [62:0]      sbit;
  logic [32:0]      rem;
  logic [14:0]      dlow;
  logic [14:0]      quo;
  logic signed [15:0] nrm [3];
  logic             res_deg;
  logic             res_st;

  logic             pos_we;
  logic [AW-1:0]    pos_addr;
  logic [47:0]      pos_rdata;
  logic             acc_we;
  logic [AW-1:0]    acc_addr;
  logic [143:0]     acc_wdata;
  logic [143:0]     acc_rdata;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] prod;

  logic [CMP_W-1:0] eff;
  logic             in_acc;
  logic             tri_ok;
  logic             load_ok;
  logic             rd_ok;
  logic [SUM_W-1:0] sum_next;
  logic [62:0]      r_plus;
  logic [31:0]      len;
  logic [44:0]      num;
  logic [32:0]      sh;
  logic             qbit;
  logic [14:0]      quo_next;
  logic [14:0]      qclamp;
  logic             out_load;
  acc_t             acc_old [3];
  logic signed [48:0] acc_sum [3];
  acc_t             acc_new [3];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign eff = (CMP_W'(vertex_count) < CMP_W'(VERTICES)) ?
               CMP_W'(vertex_count) : CMP_W'(VERTICES);
  assign tri_ok = !corner_a[11] && !corner_b[11] && !corner_c[11] &&
                  (CMP_W'(unsigned'(corner_a)) < eff) &&
                  (CMP_W'(unsigned'(corner_b)) < eff) &&
                  (CMP_W'(unsigned'(corner_c)) < eff);
  assign load_ok = CMP_W'(vertex) < CMP_W'(VERTICES);
  assign rd_ok   = CMP_W'(vertex) < eff;

  vna_ram #(.WIDTH(48), .DEPTH(VERTICES)) u_pos (
    .clk(clk), .we(pos_we), .addr(pos_addr),
    .wdata({pos_x, pos_y, pos_z}), .rdata(pos_rdata)
  );

  vna_ram #(.WIDTH(144), .DEPTH(VERTICES)) u_acc (
    .clk(clk), .we(acc_we), .addr(acc_addr),
    .wdata(acc_wdata), .rdata(acc_rdata)
  );

  vna_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));

  // saturating accumulate of the cross product
  always_comb begin
    acc_old[0] = acc_rdata[143:96];
    acc_old[1] = acc_rdata[95:48];
    acc_old[2] = acc_rdata[47:0];
    for (int n = 0; n < 3; n++) begin
      acc_sum[n] = 49'(acc_old[n]) + 49'(cr[n]);
      if (acc_sum[n][48] != acc_sum[n][47]) begin
        acc_new[n] = acc_sum[n][48] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_new[n] = acc_sum[n][47:0];
      end
    end
  end

  always_comb begin
    pos_we    = 1'b0;
    pos_addr  = AW'(vertex);
    acc_we    = 1'b0;
    acc_addr  = AW'(vertex);
    acc_wdata = '0;
    case (state)
      S_CLR: begin
        acc_we   = 1'b1;
        acc_addr = clr_addr;
      end
      S_IDLE: begin
        if (in_acc && mode == MODE_LOAD && load_ok) begin
          pos_we = 1'b1;
          acc_we = 1'b1;
        end
      end
      S_TRI: begin
        pos_addr = (k[1:0] < 2'd3) ? idx[k[1:0]] : idx[2];
      end
      S_ACC: begin
        acc_addr  = idx[k[2:1]];
        acc_we    = k[0];
        acc_wdata = {acc_new[0], acc_new[1], acc_new[2]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state == S_MUL) begin
      case (k)
        3'd0: begin op_a = 32'(e1[1]); op_b = 32'(e2[2]); end
        3'd1: begin op_a = 32'(e1[2]); op_b = 32'(e2[1]); end
        3'd2: begin op_a = 32'(e1[2]); op_b = 32'(e2[0]); end
        3'd3: begin op_a = 32'(e1[0]); op_b = 32'(e2[2]); end
        3'd4: begin op_a = 32'(e1[0]); op_b = 32'(e2[1]); end
        3'd5: begin op_a = 32'(e1[1]); op_b = 32'(e2[0]); end
        default: begin end
      endcase
    end else if (state == S_SQ && k < 3'd3) begin
      op_a = 32'({2'b00, m[k[1:0]][29:0]});
      op_b = 32'({2'b00, m[k[1:0]][29:0]});
    end
  end

  assign sum_next = sum + prod[SUM_W-1:0];
  assign r_plus   = sr + sbit;
  assign len      = (sr[31:0] == 32'd0) ? 32'd1 : sr[31:0];
  assign num      = 45'({m[i][29:0], 14'b0}) + 45'(len[31:1]);
  assign sh       = {rem[31:0], dlow[14]};
  assign qbit     = sh >= {1'b0, len};
  assign quo_next = {quo[13:0], qbit};
  assign qclamp   = (quo_next > 15'd16384) ? 15'd16384 : quo_next;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLR;
      clr_addr           <= '0;
      vertex_count       <= '0;
      min_length_squared <= THR_RESET;
      out_valid          <= 1'b0;
      k                  <= '0;
      cnt                <= '0;
      i                  <= '0;
      chk                <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_VCOUNT) begin
          vertex_count <= cfg_data[CNT_W-1:0];
        end else if (cfg_index == CFG_MINLEN) begin
          min_length_squared <= cfg_data;
        end
      end
      out_valid <= out_load || (out_valid && out_stall);
      if (out_load) begin
        norm_x     <= nrm[0];
        norm_y     <= nrm[1];
        norm_z     <= nrm[2];
        degenerate <= res_deg;
        status     <= res_st;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(VERTICES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          k <= '0;
          if (in_acc && mode == MODE_TRI && tri_ok) begin
            idx[0] <= AW'(unsigned'(corner_a));
            idx[1] <= AW'(unsigned'(corner_b));
            idx[2] <= AW'(unsigned'(corner_c));
            state  <= S_TRI;
          end else if (in_acc && mode == MODE_READ) begin
            if (rd_ok) begin
              state <= S_RDN;
            end else begin
              nrm[0]  <= '0;
              nrm[1]  <= '0;
              nrm[2]  <= '0;
              res_deg <= 1'b0;
              res_st  <= 1'b1;
              state   <= S_OUT;
            end
          end
        end
        S_TRI: begin
          k <= k + 1'b1;
          case (k)
            3'd1: begin
              pa[0] <= pos_rdata[47:32]; pa[1] <= pos_rdata[31:16]; pa[2] <= pos_rdata[15:0];
            end
            3'd2: begin
              pb[0] <= pos_rdata[47:32]; pb[1] <= pos_rdata[31:16]; pb[2] <= pos_rdata[15:0];
            end
            3'd3: begin
              pc[0] <= pos_rdata[47:32]; pc[1] <= pos_rdata[31:16]; pc[2] <= pos_rdata[15:0];
              state <= S_EDGE;
            end
            default: begin
            end
          endcase
        end
        S_EDGE: begin
          for (int n = 0; n < 3; n++) begin
            e1[n] <= 17'(pb[n]) - 17'(pa[n]);
            e2[n] <= 17'(pc[n]) - 17'(pa[n]);
          end
          k     <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (k == 3'd6) begin
            k     <= '0;
            state <= S_ACC;
          end else begin
            k <= k + 1'b1;
          end
          case (k)
            3'd1: cr[0] <= prod[CR_W-1:0];
            3'd2: cr[0] <= cr[0] - prod[CR_W-1:0];
            3'd3: cr[1] <= prod[CR_W-1:0];
            3'd4: cr[1] <= cr[1] - prod[CR_W-1:0];
            3'd5: cr[2] <= prod[CR_W-1:0];
            3'd6: cr[2] <= cr[2] - prod[CR_W-1:0];
            default: begin
            end
          endcase
        end
        S_ACC: begin
          k <= k + 1'b1;
          if (k == 3'd5) begin
            state <= S_IDLE;
          end
        end
        S_RDN: begin
          for (int n = 0; n < 3; n++) begin
            m[n]   <= acc_old[n][47] ? 48'(-acc_old[n]) : 48'(acc_old[n]);
            sgn[n] <= acc_old[n][47];
          end
          state <= S_DEG;
        end
        S_DEG: begin
          sum <= '0;
          k   <= '0;
          if ((|m[0][47:16]) || (|m[1][47:16]) || (|m[2][47:16])) begin
            chk   <= 1'b0;
            state <= S_SHF;
          end else begin
            chk   <= 1'b1;
            state <= S_SQ;
          end
        end
        S_SHF: begin
          if ((|m[0][47:30]) || (|m[1][47:30]) || (|m[2][47:30])) begin
            for (int n = 0; n < 3; n++) begin
              m[n] <= m[n] >> 1;
            end
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          k <= k + 1'b1;
          if (k != 3'd0) begin
            sum <= sum_next;
          end
          if (k == 3'd3) begin
            if (chk && sum_next <= SUM_W'(min_length_squared)) begin
              nrm[0]  <= '0;
              nrm[1]  <= '0;
              nrm[2]  <= NORM_ONE;
              res_deg <= 1'b1;
              res_st  <= 1'b0;
              state   <= S_OUT;
            end else begin
              sx    <= sum_next;
              sr    <= '0;
              sbit  <= 63'(1) << 62;
              cnt   <= '0;
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if ({1'b0, sx} >= r_plus) begin
            sx <= sx - r_plus[SUM_W-1:0];
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
          if (cnt == 5'd31) begin
            i     <= '0;
            k     <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt == 5'd0) begin
            rem  <= 33'(num[44:15]);
            dlow <= num[14:0];
            quo  <= '0;
            cnt  <= cnt + 1'b1;
          end else begin
            rem  <= qbit ? sh - {1'b0, len} : sh;
            dlow <= dlow << 1;
            quo  <= quo_next;
            if (cnt == 5'd15) begin
              nrm[i] <= sgn[i] ? -16'(qclamp) : 16'(qclamp);
              cnt    <= '0;
              if (i == 2'd2) begin
                res_deg <= 1'b0;
                res_st  <= 1'b0;
                state   <= S_OUT;
              end else begin
                i <= i + 1'b1;
              end
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_read_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc && mode == MODE_READ |=> state != S_IDLE)
    else $error("read beat did not start a result");

  a_degenerate_default: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> norm_x == 16'sd0 && norm_y == 16'sd0 && norm_z == NORM_ONE)
    else $error("degenerate beat without default normal");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !degenerate && norm_x == 16'sd0 && norm_z == 16'sd0)
    else $error("out of range beat carries data");

  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_x <= NORM_ONE && norm_x >= -NORM_ONE &&
                  norm_y <= NORM_ONE && norm_y >= -NORM_ONE)
    else $error("normal component beyond unit");

endmodule

@@ src/vna_ram.sv @@
// generic single-port ram with registered read
module vna_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/vna_mul.sv @@
// shared signed multiplier with registered product
module vna_mul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
